// ===== rtl/abl_pkg.sv =====
package abl_pkg;

  localparam int unsigned RAW_W       = 32;
  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned SHIFT       = 8;
  localparam int unsigned COUNT_OUT_W = 10;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  typedef struct packed {
    logic accumulate;
    logic close;
    logic div_step;
    logic load_out;
  } abl_cmd_t;

  typedef struct packed {
    logic close_hit;
    logic div_last;
  } abl_sts_t;

endpackage

// ===== rtl/abl_ctrl.sv =====
module abl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  abl_pkg::abl_sts_t sts_i,
  output abl_pkg::abl_cmd_t cmd_o
);
  import abl_pkg::*;

  typedef enum logic [1:0] {
    S_ACC,
    S_DIV,
    S_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_ACC);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    state_d          = state_q;
    cmd_o.accumulate = in_valid_i && (state_q == S_ACC);
    cmd_o.close      = cmd_o.accumulate && sts_i.close_hit;
    case (state_q)
      S_ACC: begin
        if (cmd_o.close) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/abl_datapath.sv =====
module abl_datapath #(
  parameter int unsigned MAX_BLOCK = 512
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic signed [abl_pkg::RAW_W-1:0]          raw_word_i,
  input  logic                                      block_end_i,
  input  abl_pkg::abl_cmd_t                         cmd_i,
  output abl_pkg::abl_sts_t                         sts_o,
  output logic        [abl_pkg::COUNT_OUT_W-1:0]    sample_count_o,
  output logic signed [abl_pkg::SAMPLE_W-1:0]       min_level_o,
  output logic signed [abl_pkg::SAMPLE_W-1:0]       max_level_o,
  output logic        [abl_pkg::SAMPLE_W-1:0]       mean_abs_level_o
);
  import abl_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SUM_W  = CNT_W + SAMPLE_W;
  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic signed [SAMPLE_W-1:0] sample;
  logic        [SAMPLE_W-1:0] mag;
  logic signed [SAMPLE_W-1:0] new_min, new_max;
  logic        [SUM_W-1:0]    new_sum;
  logic        [CNT_W-1:0]    new_cnt;

  logic signed [SAMPLE_W-1:0] min_q, min_d, max_q, max_d;
  logic        [SUM_W-1:0]    sum_q, sum_d;
  logic        [CNT_W-1:0]    cnt_q, cnt_d;

  logic signed [SAMPLE_W-1:0] snap_min_q, snap_max_q;
  logic        [CNT_W-1:0]    snap_cnt_q;
  logic        [SUM_W-1:0]    dvd_q, dvd_d;
  logic        [CNT_W-1:0]    rem_q, rem_d;
  logic        [STEP_W-1:0]   step_q, step_d;
  logic        [CNT_W:0]      trial;
  logic                       q_bit;
  logic        [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign sample  = raw_word_i[RAW_W-1:SHIFT];
  assign mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign new_min = (sample < min_q) ? sample : min_q;
  assign new_max = (sample > max_q) ? sample : max_q;
  assign new_sum = sum_q + {{CNT_W{1'b0}}, mag};
  assign new_cnt = cnt_q + 1'b1;

  assign sts_o.close_hit = block_end_i || (new_cnt == CNT_W'(MAX_BLOCK));
  assign sts_o.div_last  = (step_q == STEP_W'(SUM_W - 1));

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign q_bit = (trial >= {1'b0, snap_cnt_q});

  always_comb begin
    min_d  = min_q;
    max_d  = max_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    step_d = step_q;
    if (cmd_i.accumulate) begin
      if (cmd_i.close) begin
        min_d = SAMPLE_MAX;
        max_d = SAMPLE_MIN;
        sum_d = '0;
        cnt_d = '0;
        dvd_d  = new_sum;
        rem_d  = '0;
        step_d = '0;
      end else begin
        min_d = new_min;
        max_d = new_max;
        sum_d = new_sum;
        cnt_d = new_cnt;
      end
    end
    if (cmd_i.div_step) begin
      dvd_d  = {dvd_q[SUM_W-2:0], q_bit};
      rem_d  = q_bit ? CNT_W'(trial - {1'b0, snap_cnt_q}) : trial[CNT_W-1:0];
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= SAMPLE_MAX;
      max_q <= SAMPLE_MIN;
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, snap_cnt_q};

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    if (cmd_i.close) begin
      snap_min_q <= new_min;
      snap_max_q <= new_max;
      snap_cnt_q <= new_cnt;
    end
    if (cmd_i.load_out) begin
      sample_count_o   <= cnt_ext[COUNT_OUT_W-1:0];
      min_level_o      <= snap_min_q;
      max_level_o      <= snap_max_q;
      mean_abs_level_o <= dvd_q[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== rtl/audio_block_level_stats.sv =====
// samples are taken one per cycle while a block accumulates
// the closing sample starts a bit-serial divider of clog2(MAX_BLOCK+1)+24 steps
// input is held off from the closing sample until the result is loaded
// asynchronous active-low reset clears the accumulators and the output valid
module audio_block_level_stats #(
  parameter int unsigned MAX_BLOCK = 512
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [abl_pkg::RAW_W-1:0]       raw_word_i,
  input  logic                                   block_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic        [abl_pkg::COUNT_OUT_W-1:0] sample_count_o,
  output logic signed [abl_pkg::SAMPLE_W-1:0]    min_level_o,
  output logic signed [abl_pkg::SAMPLE_W-1:0]    max_level_o,
  output logic        [abl_pkg::SAMPLE_W-1:0]    mean_abs_level_o
);
  import abl_pkg::*;

  abl_cmd_t cmd;
  abl_sts_t sts;

  abl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  abl_datapath #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .raw_word_i      (raw_word_i),
    .block_end_i     (block_end_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .sample_count_o  (sample_count_o),
    .min_level_o     (min_level_o),
    .max_level_o     (max_level_o),
    .mean_abs_level_o(mean_abs_level_o)
  );

`ifndef ASSERT_OFF
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_abs_level_o <= 24'd8388608))
    else $error("mean level out of range");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (min_level_o <= max_level_o))
    else $error("min level above max level");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((MAX_BLOCK > 1023) || (sample_count_o != '0)))
    else $error("empty block reported");

  a_no_input_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !in_ready_o)
    else $error("input accepted during division");
`endif

endmodule
